>>> rtl/core/sorted_insert_queue_with_queries_core_defines.svh
// assertion macros for the sorted insert queue core
`ifndef SORTED_INSERT_QUEUE_WITH_QUERIES_CORE_DEFINES_SVH
`define SORTED_INSERT_QUEUE_WITH_QUERIES_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SIQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/siq_pkg.sv
// shared types and constants of the sorted insert queue
package siq_pkg;

    localparam int ID_W   = 16;
    localparam int TIME_W = 16;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_QUERY  = 2'd2
    } siq_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic            ins;
        logic            member;
        logic [ID_W-1:0] ident;
    } siq_cell_ctl_t;

    // update request for the query tracker
    typedef struct packed {
        logic            ins;
        logic            clr;
        logic            member;
        logic [ID_W-1:0] ident;
        logic            cnt_zero;
    } siq_upd_t;

    // query answers held by the tracker
    typedef struct packed {
        logic            member_found;
        logic [ID_W-1:0] last_member_id;
        logic            supporter_found;
        logic [ID_W-1:0] first_supporter_id;
        logic [ID_W-1:0] last_id;
    } siq_query_t;

endpackage

>>> rtl/core/sorted_insert_queue_with_queries_core.sv
// top level of the sorted insert queue with queries
//
// usage:
// - input channel (in_valid/in_ready) carries one item: op, arrival_time,
//   is_member, entry_id; op insert adds an entry, clear empties the table,
//   query (and the unused code) only reports
// - output channel (out_valid/out_ready) returns one result per item: count,
//   empty flag, first/last entry, last member, first supporter, drop flag
// - entries sit in a chain of CAPACITY cells sorted by arrival time; on an
//   insert every cell compares its own key and keeps, takes the new entry or
//   takes its left neighbor's entry, all in the same cycle
// - out_valid rises in the cycle after acceptance; one item per cycle is
//   accepted as long as the result register is empty or being drained
// - the per-cell compare followed by the keep/take/shift select sets the
//   cycle time; no search across the chain is needed because a small
//   tracker keeps the tail, last member and first supporter up to date
// - if out_ready stays low the result is held and in_ready drops, so the
//   table does not change until the result is taken
// - reset empties the table (count zero) and clears the result register;
//   slot contents are not cleared, an empty slot is never reported
`include "sorted_insert_queue_with_queries_core_defines.svh"

module sorted_insert_queue_with_queries_core
    import siq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [TIME_W-1:0] arrival_time,
    input  logic              is_member,
    input  logic [ID_W-1:0]   entry_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CNT_W-1:0]  count,
    output logic              is_empty,
    output logic [ID_W-1:0]   first_id,
    output logic [TIME_W-1:0] first_time,
    output logic [ID_W-1:0]   last_id,
    output logic              member_found,
    output logic [ID_W-1:0]   last_member_id,
    output logic              supporter_found,
    output logic [ID_W-1:0]   first_supporter_id,
    output logic              dropped
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                dropped_reg;
    logic                dropped_next;

    logic                in_fire;
    logic                full;
    logic                do_ins;
    logic                do_clr;
    logic [KEY_BITS-1:0] key;

    siq_cell_ctl_t       cell_ctl;
    siq_upd_t            upd;
    siq_query_t          query;

    logic                cell_lt     [CAPACITY];
    logic [KEY_BITS-1:0] cell_time   [CAPACITY];
    logic                cell_member [CAPACITY];
    logic [ID_W-1:0]     cell_ident  [CAPACITY];

    // result register frees the input side as soon as it drains
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // key masked or widened to the stored key width
    assign key  = KEY_BITS'(arrival_time);
    assign full = (fill_reg == FILL_W'(CAPACITY));

    always_comb
    begin
        do_ins = 1'b0;
        do_clr = 1'b0;
        case (op)
            OP_INSERT: do_ins = in_fire && !full;
            OP_CLEAR:  do_clr = in_fire;
            default:   ;
        endcase
    end

    // fill count and drop flag
    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        if (in_fire)
        begin
            dropped_next = (op == OP_INSERT) && full;
            if (do_clr)
                fill_next = '0;
            else if (do_ins)
                fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            dropped_reg   <= dropped_next;
        end
    end

    // insert broadcast to the chain
    assign cell_ctl.ins    = do_ins;
    assign cell_ctl.member = is_member;
    assign cell_ctl.ident  = entry_id;

    // sorted chain: cell 0 holds the earliest entry
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic occupied;

        assign occupied = (fill_reg > FILL_W'(i));

        if (i == 0)
        begin : g_head
            // head cell always takes the new entry when its own key is not smaller
            siq_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (cell_ctl),
                .key         (key),
                .occupied    (occupied),
                .prev_lt     (1'b1),
                .prev_time   (key),
                .prev_member (is_member),
                .prev_ident  (entry_id),
                .lt          (cell_lt[i]),
                .slot_time   (cell_time[i]),
                .slot_member (cell_member[i]),
                .slot_ident  (cell_ident[i])
            );
        end
        else
        begin : g_body
            siq_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (cell_ctl),
                .key         (key),
                .occupied    (occupied),
                .prev_lt     (cell_lt[i-1]),
                .prev_time   (cell_time[i-1]),
                .prev_member (cell_member[i-1]),
                .prev_ident  (cell_ident[i-1]),
                .lt          (cell_lt[i]),
                .slot_time   (cell_time[i]),
                .slot_member (cell_member[i]),
                .slot_ident  (cell_ident[i])
            );
        end
    end

    // tracker follows the same inserts and clears as the chain
    assign upd.ins      = do_ins;
    assign upd.clr      = do_clr;
    assign upd.member   = is_member;
    assign upd.ident    = entry_id;
    assign upd.cnt_zero = (fill_reg == '0);

    siq_track #(
        .KEY_BITS (KEY_BITS)
    ) u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .key   (key),
        .query (query)
    );

    // results come straight from the state, which holds while out_valid waits
    assign out_valid          = out_valid_reg;
    assign count              = CNT_W'(fill_reg);
    assign is_empty           = (fill_reg == '0);
    assign first_id           = is_empty ? '0 : cell_ident[0];
    assign first_time         = is_empty ? '0 : TIME_W'(cell_time[0]);
    assign last_id            = is_empty ? '0 : query.last_id;
    assign member_found       = query.member_found;
    assign last_member_id     = query.last_member_id;
    assign supporter_found    = query.supporter_found;
    assign first_supporter_id = query.first_supporter_id;
    assign dropped            = dropped_reg;

    `SIQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(CAPACITY),
        "fill count above capacity")
    `SIQ_ASSERT_NOW(a_drop_only_full, out_valid_reg && dropped_reg, full,
        "drop reported while table not full")
    `SIQ_ASSERT_NEXT(a_clear_empties, in_fire && (op == OP_CLEAR), is_empty,
        "clear did not empty the table")
    `SIQ_ASSERT_NOW(a_empty_no_found, is_empty,
        !query.member_found && !query.supporter_found,
        "found flag set on empty table")
    `SIQ_ASSERT_NEXT(a_stall_holds, out_valid_reg && !out_ready, $stable(fill_reg),
        "table changed while result stalled")

endmodule

>>> rtl/core/siq_cell.sv
// one slot of the sorted shift chain
module siq_cell
    import siq_pkg::*;
#(
    parameter int KEY_BITS = 16
) (
    input  logic                clk,
    input  siq_cell_ctl_t       ctl,
    input  logic [KEY_BITS-1:0] key,
    input  logic                occupied,
    input  logic                prev_lt,
    input  logic [KEY_BITS-1:0] prev_time,
    input  logic                prev_member,
    input  logic [ID_W-1:0]     prev_ident,
    output logic                lt,
    output logic [KEY_BITS-1:0] slot_time,
    output logic                slot_member,
    output logic [ID_W-1:0]     slot_ident
);

    logic [KEY_BITS-1:0] time_reg;
    logic                member_reg;
    logic [ID_W-1:0]     ident_reg;

    // stored entry sorts strictly before the new key
    assign lt = occupied && (time_reg < key);

    // keep, take the new entry, or take the neighbor's entry
    always_ff @(posedge clk)
    begin
        if (ctl.ins && !lt)
        begin
            if (prev_lt)
            begin
                time_reg   <= key;
                member_reg <= ctl.member;
                ident_reg  <= ctl.ident;
            end
            else
            begin
                time_reg   <= prev_time;
                member_reg <= prev_member;
                ident_reg  <= prev_ident;
            end
        end
    end

    assign slot_time   = time_reg;
    assign slot_member = member_reg;
    assign slot_ident  = ident_reg;

endmodule

>>> rtl/core/siq_track.sv
// incremental tracker for last entry, last member and first supporter
module siq_track
    import siq_pkg::*;
#(
    parameter int KEY_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  siq_upd_t            upd,
    input  logic [KEY_BITS-1:0] key,
    output siq_query_t          query
);

    logic                mf_reg;
    logic                sf_reg;
    logic [ID_W-1:0]     lm_id_reg;
    logic [KEY_BITS-1:0] lm_time_reg;
    logic [ID_W-1:0]     fs_id_reg;
    logic [KEY_BITS-1:0] fs_time_reg;
    logic [ID_W-1:0]     last_id_reg;
    logic [KEY_BITS-1:0] last_time_reg;
    logic                take_lm;
    logic                take_fs;
    logic                take_last;

    // new member lands after the current last member
    assign take_lm   = upd.member && (!mf_reg || (lm_time_reg < key));
    // new supporter lands at or before the current first supporter
    assign take_fs   = !upd.member && (!sf_reg || !(fs_time_reg < key));
    // new entry goes to the tail
    assign take_last = upd.cnt_zero || (last_time_reg < key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mf_reg <= 1'b0;
            sf_reg <= 1'b0;
        end
        else if (upd.clr)
        begin
            mf_reg <= 1'b0;
            sf_reg <= 1'b0;
        end
        else if (upd.ins)
        begin
            if (take_lm)
                mf_reg <= 1'b1;
            if (take_fs)
                sf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.ins)
        begin
            if (take_lm)
            begin
                lm_id_reg   <= upd.ident;
                lm_time_reg <= key;
            end
            if (take_fs)
            begin
                fs_id_reg   <= upd.ident;
                fs_time_reg <= key;
            end
            if (take_last)
            begin
                last_id_reg   <= upd.ident;
                last_time_reg <= key;
            end
        end
    end

    assign query.member_found       = mf_reg;
    assign query.last_member_id     = mf_reg ? lm_id_reg : '0;
    assign query.supporter_found    = sf_reg;
    assign query.first_supporter_id = sf_reg ? fs_id_reg : '0;
    assign query.last_id            = last_id_reg;

endmodule

>>> test/sorted_queue_checker.sv
// checker for the sorted insert queue: tracks the table and compares every result
`timescale 1ns / 1ps

module sorted_queue_checker
    import siq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        op,
    input  logic [TIME_W-1:0] arrival_time,
    input  logic              is_member,
    input  logic [ID_W-1:0]   entry_id,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CNT_W-1:0]  count,
    input  logic              is_empty,
    input  logic [ID_W-1:0]   first_id,
    input  logic [TIME_W-1:0] first_time,
    input  logic [ID_W-1:0]   last_id,
    input  logic              member_found,
    input  logic [ID_W-1:0]   last_member_id,
    input  logic              supporter_found,
    input  logic [ID_W-1:0]   first_supporter_id,
    input  logic              dropped,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic [ID_W-1:0]   first_id;
        logic [TIME_W-1:0] first_time;
        logic [ID_W-1:0]   last_id;
        logic              member_found;
        logic [ID_W-1:0]   last_member_id;
        logic              supporter_found;
        logic [ID_W-1:0]   first_supporter_id;
        logic              dropped;
    } queue_report_t;

    // shadow copy of the sorted table
    logic [31:0]     slot_key       [CAPACITY];
    logic            slot_is_member [CAPACITY];
    logic [ID_W-1:0] slot_tag       [CAPACITY];
    int              held;

    queue_report_t   reports_due[$];
    int              fail_count = 0;
    int              due_count = 0;

    assign errors  = fail_count;
    assign pending = due_count;

    function automatic queue_report_t apply_item(
        input logic [1:0]        code,
        input logic [TIME_W-1:0] t_in,
        input logic              m,
        input logic [ID_W-1:0]   id
    );
        queue_report_t rep;
        logic [31:0]   key;
        int            pos;
        rep = '0;
        key = 32'(t_in) & 32'((64'd1 << KEY_BITS) - 64'd1);
        if (code == OP_INSERT)
        begin
            if (held >= CAPACITY)
            begin
                rep.dropped = 1'b1;
            end
            else
            begin
                // newest entry goes ahead of equal keys
                pos = 0;
                while (pos < held && slot_key[pos] < key)
                    pos++;
                for (int k = held; k > pos; k--)
                begin
                    slot_key[k]       = slot_key[k-1];
                    slot_is_member[k] = slot_is_member[k-1];
                    slot_tag[k]       = slot_tag[k-1];
                end
                slot_key[pos]       = key;
                slot_is_member[pos] = m;
                slot_tag[pos]       = id;
                held++;
            end
        end
        else if (code == OP_CLEAR)
        begin
            held = 0;
        end
        for (int k = 0; k < held; k++)
        begin
            if (slot_is_member[k])
            begin
                rep.member_found   = 1'b1;
                rep.last_member_id = slot_tag[k];
            end
            else if (!rep.supporter_found)
            begin
                rep.supporter_found    = 1'b1;
                rep.first_supporter_id = slot_tag[k];
            end
        end
        rep.count    = CNT_W'(held);
        rep.is_empty = (held == 0);
        if (held > 0)
        begin
            rep.first_id   = slot_tag[0];
            rep.first_time = TIME_W'(slot_key[0]);
            rep.last_id    = slot_tag[held-1];
        end
        return rep;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_report(input queue_report_t want);
        compare_field("count", 32'(want.count), 32'(count));
        compare_field("is_empty", 32'(want.is_empty), 32'(is_empty));
        compare_field("first_id", 32'(want.first_id), 32'(first_id));
        compare_field("first_time", 32'(want.first_time), 32'(first_time));
        compare_field("last_id", 32'(want.last_id), 32'(last_id));
        compare_field("member_found", 32'(want.member_found), 32'(member_found));
        compare_field("last_member_id", 32'(want.last_member_id),
                      32'(last_member_id));
        compare_field("supporter_found", 32'(want.supporter_found),
                      32'(supporter_found));
        compare_field("first_supporter_id", 32'(want.first_supporter_id),
                      32'(first_supporter_id));
        compare_field("dropped", 32'(want.dropped), 32'(dropped));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            reports_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                reports_due.push_back(apply_item(op, arrival_time, is_member, entry_id));
            if (out_valid && out_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("result with no item waiting");
                    fail_count++;
                end
                else
                begin
                    compare_report(reports_due.pop_front());
                end
            end
            due_count <= reports_due.size();
        end
    end

endmodule

>>> test/sorted_insert_queue_with_queries_core_test.sv
// testbench top for the sorted insert queue core: stimulus, idling and verdict
`timescale 1ns / 1ps

module sorted_insert_queue_with_queries_core_test;
    import siq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    // the fourth op code is unused and must act as a query
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // random items per idling phase
    localparam int PHASE_ITEMS = 210;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [TIME_W-1:0] arrival_time;
    logic              is_member;
    logic [ID_W-1:0]   entry_id;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic [ID_W-1:0]   first_id;
    logic [TIME_W-1:0] first_time;
    logic [ID_W-1:0]   last_id;
    logic              member_found;
    logic [ID_W-1:0]   last_member_id;
    logic              supporter_found;
    logic [ID_W-1:0]   first_supporter_id;
    logic              dropped;

    // percent of cycles in which each side holds back
    int                send_idle = 34;
    int                recv_idle = 56;
    int                errors;
    int                pending;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_insert_queue_with_queries_core #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .arrival_time       (arrival_time),
        .is_member          (is_member),
        .entry_id           (entry_id),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .count              (count),
        .is_empty           (is_empty),
        .first_id           (first_id),
        .first_time         (first_time),
        .last_id            (last_id),
        .member_found       (member_found),
        .last_member_id     (last_member_id),
        .supporter_found    (supporter_found),
        .first_supporter_id (first_supporter_id),
        .dropped            (dropped)
    );

    sorted_queue_checker #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .arrival_time       (arrival_time),
        .is_member          (is_member),
        .entry_id           (entry_id),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .count              (count),
        .is_empty           (is_empty),
        .first_id           (first_id),
        .first_time         (first_time),
        .last_id            (last_id),
        .member_found       (member_found),
        .last_member_id     (last_member_id),
        .supporter_found    (supporter_found),
        .first_supporter_id (first_supporter_id),
        .dropped            (dropped),
        .errors             (errors),
        .pending            (pending)
    );

    // result side: random back-pressure, one draw per clock
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // offer one item, holding it steady until it is taken
    // returns at the edge where the item was accepted, so the next call
    // either keeps valid high or drops it, never both in one step
    task automatic send_item(
        input logic [1:0]        code,
        input logic [TIME_W-1:0] t,
        input logic              m,
        input logic [ID_W-1:0]   id
    );
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= code;
        arrival_time <= t;
        is_member    <= m;
        entry_id     <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // sort keys: extremes, a narrow band to force ties, or anything
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return TIME_W'($urandom_range(0, 7));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    // bursts of inserts with a few queries mixed in, then sometimes a clear;
    // bursts run long enough to fill the table and hit the drop case
    task automatic run_random(input int n_items);
        int done;
        int burst;
        int pick;
        done = 0;
        while (done < n_items) begin
            burst = $urandom_range(1, 22);
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    send_item(OP_QUERY, pick_time(), 1'($urandom), ID_W'($urandom));
                else if (pick < 11)
                    send_item(OP_UNUSED, pick_time(), 1'($urandom), ID_W'($urandom));
                else if (pick < 13)
                    send_item(OP_CLEAR, pick_time(), 1'($urandom), ID_W'($urandom));
                else
                    send_item(OP_INSERT, pick_time(), 1'($urandom), ID_W'($urandom));
                done++;
            end
            if ($urandom_range(99) < 45) begin
                send_item(OP_CLEAR, pick_time(), 1'($urandom), ID_W'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_QUERY;
        arrival_time <= '0;
        is_member    <= 1'b0;
        entry_id     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, unused op, key and id extremes
        send_item(OP_QUERY, '0, 1'b0, '0);
        send_item(OP_UNUSED, '1, 1'b1, '1);
        send_item(OP_INSERT, '1, 1'b0, '0);
        send_item(OP_INSERT, '0, 1'b1, '1);
        // equal key: newest lands in front
        send_item(OP_INSERT, '0, 1'b1, 16'h1234);
        // query and clear ignore their payload
        send_item(OP_QUERY, 16'hA5A5, 1'b1, 16'h5A5A);
        send_item(OP_CLEAR, 16'h5A5A, 1'b1, 16'hA5A5);
        // fill to capacity, then one insert too many
        for (int k = 0; k < CAPACITY; k++)
            send_item(OP_INSERT, pick_time(), 1'(k), ID_W'($urandom));
        send_item(OP_INSERT, 16'h8000, 1'b1, 16'hBEEF);
        send_item(OP_UNUSED, '0, 1'b0, '0);

        // random part in three idling phases
        run_random(PHASE_ITEMS);
        send_idle = 56;
        recv_idle = 34;
        run_random(PHASE_ITEMS);
        send_idle = 0;
        recv_idle = 0;
        run_random(PHASE_ITEMS);
        in_valid <= 1'b0;

        // drain: wait for every result, then keep watching for stray outputs
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
